// File: rtl/blat_pkg.sv
// shared constants, types and request codes of the binary lifting ancestor table
package blat_pkg;

  localparam int NODE_W = 10;
  localparam int NODES = 1 << NODE_W;
  localparam int LEVELS = 10;
  localparam int IDX_W = $clog2(LEVELS);
  localparam int DEP_W = 10;
  localparam int STEP_W = 10;
  localparam int KIND_W = 2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [DEP_W-1:0] depth_t;
  typedef logic [STEP_W-1:0] steps_t;
  typedef logic [IDX_W-1:0] lvl_t;
  typedef node_t [LEVELS-1:0] row_t;

  localparam depth_t DEPTH_MAX = {DEP_W{1'b1}};
  localparam node_t NODE_LAST = {NODE_W{1'b1}};
  localparam lvl_t LVL_LAST = lvl_t'(LEVELS - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD = 2'd0,
    KIND_LCA    = 2'd1,
    KIND_JUMP   = 2'd2,
    KIND_DEPTH  = 2'd3
  } kind_t;

  typedef struct packed {
    logic   en;
    node_t  addr;
    depth_t depth;
    row_t   row;
  } wr_t;

  typedef struct packed {
    depth_t dep_a;
    depth_t dep_b;
    row_t   row_a;
    row_t   row_b;
  } rd_t;

endpackage

// File: rtl/binary_lifting_ancestor_table_core.sv
// binary lifting ancestor table: record, jump, lowest common ancestor and depth requests
// One request at a time, one result per request. After reset the block clears all 1024
// entries of both stores and stalls its input meanwhile. Every lookup that depends on the
// previous one passes through a wait state, since the stores return registered read data.
// A jump reads only at the set bits of steps; a lowest common ancestor request does a
// depth read, a climb to equal depth, then a descent over all lifting levels. The output
// register frees the input side as soon as a result is handed to it.
module binary_lifting_ancestor_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [blat_pkg::KIND_W-1:0]   in_kind,
  input  logic [blat_pkg::NODE_W-1:0]   in_node_a,
  input  logic [blat_pkg::NODE_W-1:0]   in_node_b,
  input  logic [blat_pkg::STEP_W-1:0]   in_steps,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [blat_pkg::NODE_W-1:0]   out_result_node,
  output logic [blat_pkg::DEP_W-1:0]    out_result_depth
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WAIT,
    ST_REC,
    ST_JMP,
    ST_JMP_USE,
    ST_LCA_D,
    ST_LCA_CHK,
    ST_LCA_UP,
    ST_LCA_P,
    ST_FIN,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;
  blat_pkg::node_t clr_r, clr_nxt;

  blat_pkg::kind_t  kind_r, kind_nxt;
  blat_pkg::node_t  node_a_r, node_a_nxt;
  blat_pkg::node_t  cur_a_r, cur_a_nxt;
  blat_pkg::node_t  cur_b_r, cur_b_nxt;
  blat_pkg::steps_t steps_r, steps_nxt;
  blat_pkg::lvl_t   lvl_r, lvl_nxt;
  blat_pkg::row_t   row_r, row_nxt;
  blat_pkg::depth_t dep_r, dep_nxt;
  blat_pkg::node_t  res_node_r, res_node_nxt;
  blat_pkg::depth_t res_dep_r, res_dep_nxt;
  blat_pkg::node_t  out_node_r, out_node_nxt;
  blat_pkg::depth_t out_dep_r, out_dep_nxt;

  blat_pkg::wr_t wr;
  blat_pkg::rd_t rd;

  blat_pkg::lvl_t   lvl_m1;
  blat_pkg::node_t  rec_val;
  blat_pkg::depth_t dep_inc;
  blat_pkg::node_t  up_a;
  blat_pkg::node_t  up_b;
  logic             up_diff;
  state_t           climb_ret;
  logic             load;

  blat_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_addr_a (cur_a_r),
    .rd_addr_b (cur_b_r),
    .rd        (rd)
  );

  assign lvl_m1 = lvl_r - blat_pkg::lvl_t'(1);
  assign rec_val = (cur_a_r == node_a_r) ? node_a_r : rd.row_a[lvl_m1];
  assign dep_inc = (rd.dep_a == blat_pkg::DEPTH_MAX) ? blat_pkg::DEPTH_MAX
                                                     : rd.dep_a + blat_pkg::depth_t'(1);
  assign up_a = rd.row_a[lvl_r];
  assign up_b = rd.row_b[lvl_r];
  assign up_diff = (up_a != up_b);
  assign climb_ret = (kind_r == blat_pkg::KIND_LCA) ? ST_LCA_CHK : ST_FIN;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    clr_nxt = clr_r;
    kind_nxt = kind_r;
    node_a_nxt = node_a_r;
    cur_a_nxt = cur_a_r;
    cur_b_nxt = cur_b_r;
    steps_nxt = steps_r;
    lvl_nxt = lvl_r;
    row_nxt = row_r;
    dep_nxt = dep_r;
    res_node_nxt = res_node_r;
    res_dep_nxt = res_dep_r;
    load = 1'b0;
    wr.en = 1'b0;
    wr.addr = node_a_r;
    wr.depth = dep_r;
    wr.row = row_r;

    case (state_r)
      ST_CLEAR: begin
        wr.en = 1'b1;
        wr.addr = clr_r;
        wr.depth = '0;
        wr.row = '0;
        clr_nxt = clr_r + blat_pkg::node_t'(1);
        if (clr_r == blat_pkg::NODE_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = blat_pkg::kind_t'(in_kind);
          node_a_nxt = in_node_a;
          cur_a_nxt = in_node_a;
          cur_b_nxt = in_node_b;
          steps_nxt = in_steps;
          lvl_nxt = '0;
          res_node_nxt = '0;
          res_dep_nxt = '0;
          case (blat_pkg::kind_t'(in_kind))
            blat_pkg::KIND_RECORD: begin
              if (in_node_a == '0) begin
                state_nxt = ST_OUT;
              end else begin
                cur_a_nxt = in_node_b;
                row_nxt[0] = in_node_b;
                lvl_nxt = blat_pkg::lvl_t'(1);
                ret_nxt = ST_REC;
                state_nxt = ST_WAIT;
              end
            end
            blat_pkg::KIND_LCA: begin
              if (in_node_a == in_node_b) begin
                ret_nxt = ST_FIN;
                state_nxt = ST_WAIT;
              end else if (in_node_a == '0 || in_node_b == '0) begin
                state_nxt = ST_OUT;
              end else begin
                ret_nxt = ST_LCA_D;
                state_nxt = ST_WAIT;
              end
            end
            blat_pkg::KIND_JUMP: begin
              state_nxt = ST_JMP;
            end
            default: begin
              ret_nxt = ST_FIN;
              state_nxt = ST_WAIT;
            end
          endcase
        end
      end
      ST_WAIT: begin
        state_nxt = ret_r;
      end
      ST_REC: begin
        row_nxt[lvl_r] = rec_val;
        if (lvl_r == blat_pkg::lvl_t'(1)) begin
          dep_nxt = dep_inc;
        end
        if (lvl_r == blat_pkg::LVL_LAST) begin
          wr.en = 1'b1;
          wr.addr = node_a_r;
          wr.row = row_nxt;
          wr.depth = dep_nxt;
          res_node_nxt = cur_b_r;
          res_dep_nxt = dep_nxt;
          state_nxt = ST_OUT;
        end else begin
          cur_a_nxt = rec_val;
          lvl_nxt = lvl_r + blat_pkg::lvl_t'(1);
          ret_nxt = ST_REC;
          state_nxt = ST_WAIT;
        end
      end
      ST_JMP: begin
        if (steps_r[lvl_r]) begin
          ret_nxt = ST_JMP_USE;
          state_nxt = ST_WAIT;
        end else if (lvl_r == blat_pkg::LVL_LAST) begin
          ret_nxt = climb_ret;
          state_nxt = ST_WAIT;
        end else begin
          lvl_nxt = lvl_r + blat_pkg::lvl_t'(1);
        end
      end
      ST_JMP_USE: begin
        cur_a_nxt = up_a;
        if (lvl_r == blat_pkg::LVL_LAST) begin
          ret_nxt = climb_ret;
          state_nxt = ST_WAIT;
        end else begin
          lvl_nxt = lvl_r + blat_pkg::lvl_t'(1);
          state_nxt = ST_JMP;
        end
      end
      ST_LCA_D: begin
        if (rd.dep_a < rd.dep_b) begin
          cur_a_nxt = cur_b_r;
          cur_b_nxt = cur_a_r;
          steps_nxt = blat_pkg::steps_t'(rd.dep_b - rd.dep_a);
        end else begin
          steps_nxt = blat_pkg::steps_t'(rd.dep_a - rd.dep_b);
        end
        lvl_nxt = '0;
        state_nxt = ST_JMP;
      end
      ST_LCA_CHK: begin
        if (cur_a_r == cur_b_r) begin
          state_nxt = ST_FIN;
        end else begin
          lvl_nxt = blat_pkg::LVL_LAST;
          state_nxt = ST_LCA_UP;
        end
      end
      ST_LCA_UP: begin
        if (up_diff) begin
          cur_a_nxt = up_a;
          cur_b_nxt = up_b;
        end
        if (lvl_r == '0) begin
          if (up_diff) begin
            ret_nxt = ST_LCA_P;
            state_nxt = ST_WAIT;
          end else begin
            state_nxt = ST_LCA_P;
          end
        end else begin
          lvl_nxt = lvl_m1;
          if (up_diff) begin
            ret_nxt = ST_LCA_UP;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_LCA_P: begin
        cur_a_nxt = rd.row_a[0];
        ret_nxt = ST_FIN;
        state_nxt = ST_WAIT;
      end
      ST_FIN: begin
        res_node_nxt = cur_a_r;
        res_dep_nxt = rd.dep_a;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = load | (out_valid_r & out_stall);
    out_node_nxt = load ? res_node_r : out_node_r;
    out_dep_nxt = load ? res_dep_r : out_dep_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ret_r <= ST_IDLE;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      clr_r <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r <= kind_nxt;
    node_a_r <= node_a_nxt;
    cur_a_r <= cur_a_nxt;
    cur_b_r <= cur_b_nxt;
    steps_r <= steps_nxt;
    lvl_r <= lvl_nxt;
    row_r <= row_nxt;
    dep_r <= dep_nxt;
    res_node_r <= res_node_nxt;
    res_dep_r <= res_dep_nxt;
    out_node_r <= out_node_nxt;
    out_dep_r <= out_dep_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_result_node = out_node_r;
  assign out_result_depth = out_dep_r;

endmodule

// File: rtl/blat_store.sv
// depth store and ancestor row store, one write port and two registered read ports
module blat_store (
  input  logic                clk,
  input  blat_pkg::wr_t       wr,
  input  blat_pkg::node_t     rd_addr_a,
  input  blat_pkg::node_t     rd_addr_b,
  output blat_pkg::rd_t       rd
);

  blat_pkg::depth_t dep_mem [blat_pkg::NODES];
  blat_pkg::row_t   row_mem [blat_pkg::NODES];

  blat_pkg::depth_t dep_a_r;
  blat_pkg::depth_t dep_b_r;
  blat_pkg::row_t   row_a_r;
  blat_pkg::row_t   row_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      dep_mem[wr.addr] <= wr.depth;
      row_mem[wr.addr] <= wr.row;
    end
    dep_a_r <= dep_mem[rd_addr_a];
    dep_b_r <= dep_mem[rd_addr_b];
    row_a_r <= row_mem[rd_addr_a];
    row_b_r <= row_mem[rd_addr_b];
  end

  assign rd.dep_a = dep_a_r;
  assign rd.dep_b = dep_b_r;
  assign rd.row_a = row_a_r;
  assign rd.row_b = row_b_r;

endmodule

// File: bench/testbench.sv
// self-checking testbench for the binary lifting ancestor table core
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    blat_pkg::kind_t  kind;
    blat_pkg::node_t  node_a;
    blat_pkg::node_t  node_b;
    blat_pkg::steps_t steps;
  } request_t;

  typedef struct packed {
    blat_pkg::node_t  node;
    blat_pkg::depth_t depth;
  } answer_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [blat_pkg::KIND_W-1:0] in_kind = '0;
  logic [blat_pkg::NODE_W-1:0] in_node_a = '0;
  logic [blat_pkg::NODE_W-1:0] in_node_b = '0;
  logic [blat_pkg::STEP_W-1:0] in_steps = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [blat_pkg::NODE_W-1:0] out_result_node;
  logic [blat_pkg::DEP_W-1:0] out_result_depth;

  blat_pkg::depth_t depth_mem [blat_pkg::NODES];
  blat_pkg::row_t anc_mem [blat_pkg::NODES];

  request_t request_q[$];
  answer_t answer_q[$];
  blat_pkg::node_t live[$];

  int kind_count [4];
  int checked = 0;
  int mismatches = 0;
  int deepest = 0;
  int burst_left = 0;
  int gap_left = 0;
  int free_run = 0;
  int stall_run = 0;
  answer_t want;
  answer_t got;

  binary_lifting_ancestor_table_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_node_a        (in_node_a),
    .in_node_b        (in_node_b),
    .in_steps         (in_steps),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_node  (out_result_node),
    .out_result_depth (out_result_depth)
  );

  function automatic blat_pkg::node_t climb_up(blat_pkg::node_t n, blat_pkg::steps_t count);
    for (int k = 0; k < blat_pkg::LEVELS; k++) begin
      if (count[k]) begin
        n = anc_mem[n][k];
      end
    end
    return n;
  endfunction

  function automatic blat_pkg::node_t meeting_node(blat_pkg::node_t a, blat_pkg::node_t b);
    blat_pkg::node_t t;
    blat_pkg::node_t ua;
    blat_pkg::node_t ub;
    if (a == b) return a;
    if (a == '0 || b == '0) return '0;
    if (depth_mem[a] < depth_mem[b]) begin
      t = a;
      a = b;
      b = t;
    end
    a = climb_up(a, blat_pkg::steps_t'(depth_mem[a] - depth_mem[b]));
    if (a == b) return a;
    for (int k = blat_pkg::LEVELS - 1; k >= 0; k--) begin
      ua = anc_mem[a][k];
      ub = anc_mem[b][k];
      if (ua != ub) begin
        a = ua;
        b = ub;
      end
    end
    return anc_mem[a][0];
  endfunction

  function automatic answer_t ancestor_answer(request_t r);
    answer_t ans;
    blat_pkg::depth_t d;
    blat_pkg::node_t prev;
    ans = '0;
    kind_count[r.kind]++;
    case (r.kind)
      blat_pkg::KIND_RECORD: begin
        if (r.node_a != '0) begin
          d = (depth_mem[r.node_b] == blat_pkg::DEPTH_MAX) ? blat_pkg::DEPTH_MAX
                                                           : depth_mem[r.node_b] + 1'b1;
          ans.node = r.node_b;
          ans.depth = d;
          if (int'(d) > deepest) deepest = d;
          depth_mem[r.node_a] = d;
          anc_mem[r.node_a][0] = r.node_b;
          for (int k = 1; k < blat_pkg::LEVELS; k++) begin
            prev = anc_mem[r.node_a][k-1];
            anc_mem[r.node_a][k] = anc_mem[prev][k-1];
          end
        end
      end
      blat_pkg::KIND_LCA: begin
        ans.node = meeting_node(r.node_a, r.node_b);
        ans.depth = depth_mem[ans.node];
      end
      blat_pkg::KIND_JUMP: begin
        ans.node = climb_up(r.node_a, r.steps);
        ans.depth = depth_mem[ans.node];
      end
      default: begin
        ans.node = r.node_a;
        ans.depth = depth_mem[r.node_a];
      end
    endcase
    return ans;
  endfunction

  task automatic add_req(input blat_pkg::kind_t k, input int a, input int b, input int s);
    request_t r;
    r.kind = k;
    r.node_a = blat_pkg::node_t'(a);
    r.node_b = blat_pkg::node_t'(b);
    r.steps = blat_pkg::steps_t'(s);
    request_q = {request_q, r};
    if (k == blat_pkg::KIND_RECORD && r.node_a != '0) begin
      live = {live, r.node_a};
      if (live.size() > 64) void'(live.pop_front());
    end
  endtask

  function automatic blat_pkg::node_t pick_node();
    int lo;
    if (live.size() == 0) return blat_pkg::node_t'($urandom_range(1, blat_pkg::NODES - 1));
    lo = (live.size() > 8) ? live.size() - 8 : 0;
    if ($urandom_range(0, 1) == 1) return live[$urandom_range(lo, live.size() - 1)];
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic int pick_steps();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 15);
    if (r < 8) return $urandom_range(0, 63);
    return $urandom_range(0, 1023);
  endfunction

  task automatic build_random(input int total);
    int made;
    int span;
    int r;
    int a;
    int b;
    made = 0;
    while (made < total) begin
      span = $urandom_range(10, 60);
      if ($urandom_range(0, 9) < 3) live.delete();
      for (int i = 0; i < span && made < total; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          a = $urandom_range(0, 9);
          if (a < 2 && live.size() > 0) a = pick_node();
          else if (a == 2) a = blat_pkg::NODES - 1;
          else a = $urandom_range(1, blat_pkg::NODES - 1);
          b = $urandom_range(0, 99);
          if (b < 15 || live.size() == 0) b = 0;
          else if (b < 50) b = live[live.size() - 1];
          else if (b < 97) b = pick_node();
          else b = $urandom_range(0, blat_pkg::NODES - 1);
          add_req(blat_pkg::KIND_RECORD, a, b, $urandom_range(0, 1023));
        end else if (r < 65) begin
          a = pick_node();
          b = pick_node();
          if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 1) a = 0;
            else b = $urandom_range(0, blat_pkg::NODES - 1);
          end
          add_req(blat_pkg::KIND_LCA, a, b, $urandom_range(0, 1023));
        end else if (r < 83) begin
          add_req(blat_pkg::KIND_JUMP, pick_node(), $urandom_range(0, 1023), pick_steps());
        end else if (r < 93) begin
          a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, blat_pkg::NODES - 1)
                                          : pick_node();
          add_req(blat_pkg::KIND_DEPTH, a, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end else begin
          add_req(blat_pkg::kind_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        made++;
      end
    end
  endtask

  task automatic build_deep_chain();
    for (int n = 1; n < blat_pkg::NODES; n++) begin
      add_req(blat_pkg::KIND_RECORD, n, n - 1, $urandom_range(0, 1023));
      if (n % 64 == 0) begin
        add_req(blat_pkg::KIND_JUMP, n, $urandom_range(0, 1023), $urandom_range(0, 1023));
        add_req(blat_pkg::KIND_LCA, n, $urandom_range(1, n), $urandom_range(0, 1023));
        add_req(blat_pkg::KIND_LCA, $urandom_range(1, n), $urandom_range(1, n), 0);
      end
    end
    add_req(blat_pkg::KIND_RECORD, 5, blat_pkg::NODES - 1, 0);
    add_req(blat_pkg::KIND_RECORD, 6, 5, 0);
    add_req(blat_pkg::KIND_DEPTH, 6, 0, 0);
    add_req(blat_pkg::KIND_LCA, 6, 1000, 0);
    add_req(blat_pkg::KIND_JUMP, blat_pkg::NODES - 1, 0, 1023);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        answer_q = {answer_q, ancestor_answer(request_q.pop_front())};
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_valid <= 1'b1;
        in_kind <= request_q[0].kind;
        in_node_a <= request_q[0].node_a;
        in_node_b <= request_q[0].node_b;
        in_steps <= request_q[0].steps;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        got.node = out_result_node;
        got.depth = out_result_depth;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result node %0d depth %0d at %0t", got.node, got.depth, $time);
          end
        end else begin
          want = answer_q.pop_front();
          if (want.node !== got.node || want.depth !== got.depth) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: node exp %0d got %0d, depth exp %0d got %0d",
                       $time, want.node, got.node, want.depth, got.depth);
            end
          end
        end
      end
      if (stall_run > 0) begin
        stall_run <= stall_run - 1;
        out_stall <= 1'b1;
      end else if (free_run > 0) begin
        free_run <= free_run - 1;
        out_stall <= 1'b0;
      end else begin
        free_run <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
        stall_run <= $urandom_range(0, 6);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    foreach (depth_mem[i]) begin
      depth_mem[i] = '0;
      anc_mem[i] = '0;
    end
    foreach (kind_count[i]) kind_count[i] = 0;

    // root, unrecorded nodes and ignored root record
    add_req(blat_pkg::KIND_DEPTH, 0, 1023, 1023);
    add_req(blat_pkg::KIND_RECORD, 0, 5, 0);
    add_req(blat_pkg::KIND_JUMP, blat_pkg::NODES - 1, 0, 1023);
    add_req(blat_pkg::KIND_LCA, 0, 0, 0);
    add_req(blat_pkg::KIND_LCA, 7, 0, 0);
    add_req(blat_pkg::KIND_LCA, 9, 9, 0);
    // small tree with the highest node index in it
    add_req(blat_pkg::KIND_RECORD, 1, 0, 0);
    add_req(blat_pkg::KIND_RECORD, 2, 1, 0);
    add_req(blat_pkg::KIND_RECORD, 3, 1, 0);
    add_req(blat_pkg::KIND_RECORD, 4, 2, 0);
    add_req(blat_pkg::KIND_RECORD, blat_pkg::NODES - 1, 4, 1023);
    add_req(blat_pkg::KIND_RECORD, 6, blat_pkg::NODES - 1, 0);
    add_req(blat_pkg::KIND_LCA, 4, 3, 0);
    add_req(blat_pkg::KIND_LCA, blat_pkg::NODES - 1, 3, 0);
    add_req(blat_pkg::KIND_LCA, 6, 2, 0);
    add_req(blat_pkg::KIND_LCA, 2, 6, 0);
    add_req(blat_pkg::KIND_JUMP, 6, 0, 3);
    add_req(blat_pkg::KIND_JUMP, 6, 0, 1023);
    add_req(blat_pkg::KIND_JUMP, 6, 0, 0);
    add_req(blat_pkg::KIND_DEPTH, blat_pkg::NODES - 1, 0, 0);
    // self parent and an unrecorded node against a recorded one
    add_req(blat_pkg::KIND_RECORD, 7, 7, 0);
    add_req(blat_pkg::KIND_DEPTH, 7, 0, 0);
    add_req(blat_pkg::KIND_LCA, 500, 3, 0);
    add_req(blat_pkg::KIND_LCA, 7, 6, 0);
    live.delete();

    build_random(60);
    build_deep_chain();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (answer_q.size() != 0) begin
      mismatches += answer_q.size();
      $display("%0d results never arrived", answer_q.size());
    end
    $display("ran %0d records, %0d common ancestor, %0d jump and %0d depth requests",
             kind_count[blat_pkg::KIND_RECORD], kind_count[blat_pkg::KIND_LCA],
             kind_count[blat_pkg::KIND_JUMP], kind_count[blat_pkg::KIND_DEPTH]);
    $display("%0d results compared, deepest depth %0d, %0d mismatches",
             checked, deepest, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
